>>> rtl/core/window_hit_test_and_drag_unit_assert.svh
// Assertion macros shared by the window hit-test unit.
`ifndef WINDOW_HIT_TEST_AND_DRAG_UNIT_ASSERT_SVH
`define WINDOW_HIT_TEST_AND_DRAG_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define WHT_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define WHT_ASSERT_NEXT(label, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> rtl/core/wht_pkg.sv
// ----------------------------------------------------------------------------
// wht_pkg
// Types and constants of the window hit-test and drag unit.
// ----------------------------------------------------------------------------
package wht_pkg;
    localparam int MAX_WINDOWS = 16;
    localparam int SLOT_W = $clog2(MAX_WINDOWS);
    localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_FLAGS = 3'd2;
    localparam logic [2:0] OP_PRESS = 3'd3;
    localparam logic [2:0] OP_DRAG = 3'd4;
    localparam logic [2:0] OP_RELEASE = 3'd5;

    localparam logic [2:0] AREA_NONE = 3'd0;
    localparam logic [2:0] AREA_TITLE = 3'd1;
    localparam logic [2:0] AREA_BORDER = 3'd2;
    localparam logic [2:0] AREA_CONTENT = 3'd3;
    localparam logic [2:0] AREA_SCROLL = 3'd4;
    localparam logic [2:0] AREA_CLOSE = 3'd5;
    localparam logic [2:0] AREA_MIN = 3'd6;
    localparam logic [2:0] AREA_MAX = 3'd7;

    localparam logic [1:0] DRAG_IDLE = 2'd0;
    localparam logic [1:0] DRAG_MOVE = 2'd1;
    localparam logic [1:0] DRAG_RESIZE = 2'd2;
    localparam logic [1:0] DRAG_SCROLL = 2'd3;

    localparam logic CFG_MIN_WIDTH = 1'b0;
    localparam logic CFG_MIN_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] window_id;
        logic signed [11:0] win_col;
        logic signed [11:0] win_row;
        logic [10:0] win_width;
        logic [10:0] win_height;
        logic        minimized;
        logic        scrollbar_on;
        logic signed [11:0] mouse_row;
        logic signed [11:0] mouse_col;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [2:0]  hit_area;
        logic [31:0] hit_id;
        logic [1:0]  drag_mode;
        logic        changed;
        logic signed [11:0] new_col;
        logic signed [11:0] new_row;
        logic [10:0] new_width;
        logic [10:0] new_height;
        logic        resize_ended;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_CLASS, ST_DRAG, ST_COPY, ST_EXEC, ST_OUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic classify;
        logic drag_calc;
        logic copy_read;
        logic execute;
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_done;
        logic is_press;
        logic is_drag;
        logic is_remove;
    } sts_t;
endpackage

>>> rtl/core/wht_if.sv
// ----------------------------------------------------------------------------
// wht_req_if / wht_rsp_if
// Valid-ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface wht_req_if;
    import wht_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wht_rsp_if;
    import wht_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/wht_ctrl.sv
// ----------------------------------------------------------------------------
// wht_ctrl
// Sequencer: accept, table scan, classify, drag or copy, commit, hand over result.
// ----------------------------------------------------------------------------
module wht_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output wht_pkg::cmd_t   cmd,
    input  wht_pkg::sts_t   sts
);
    import wht_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    if (sts.is_press) state_next = ST_CLASS;
                    else if (sts.is_drag) state_next = ST_DRAG;
                    else if (sts.is_remove) state_next = ST_COPY;
                    else state_next = ST_EXEC;
                end
            end
            ST_CLASS: state_next = ST_EXEC;
            ST_DRAG:  state_next = ST_EXEC;
            ST_COPY:  state_next = ST_EXEC;
            ST_EXEC:  state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                cmd.scan_start = in_valid;
            end
            ST_SCAN:  cmd.scan_step = 1'b1;
            ST_CLASS: cmd.classify = 1'b1;
            ST_DRAG:  cmd.drag_calc = 1'b1;
            ST_COPY:  cmd.copy_read = 1'b1;
            ST_EXEC:  cmd.execute = 1'b1;
            ST_OUT:   out_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end

`include "window_hit_test_and_drag_unit_assert.svh"
    `WHT_ASSERT_IMP(a_ready_idle, in_ready, !out_valid)
    `WHT_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_reg == ST_SCAN)
    `WHT_ASSERT_NEXT(a_exec_out, cmd.execute, out_valid)
endmodule

>>> rtl/core/wht_dp.sv
// ----------------------------------------------------------------------------
// wht_dp
// Window table, scan, hit classification and drag arithmetic.
// ----------------------------------------------------------------------------
module wht_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  wht_pkg::req_t   req,
    output wht_pkg::rsp_t   rsp,
    input  wht_pkg::cmd_t   cmd,
    output wht_pkg::sts_t   sts,
    input  logic            cfg_we,
    input  logic            cfg_idx,
    input  logic [7:0]      cfg_data
);
    import wht_pkg::*;

    logic [31:0] e_id [MAX_WINDOWS];
    logic signed [11:0] e_col [MAX_WINDOWS];
    logic signed [11:0] e_row [MAX_WINDOWS];
    logic [10:0] e_w [MAX_WINDOWS];
    logic [10:0] e_h [MAX_WINDOWS];
    logic [31:0] e_z [MAX_WINDOWS];
    logic [1:0]  e_fl [MAX_WINDOWS];

    logic [7:0] min_w_reg, min_h_reg;
    logic [CNT_W-1:0] count_reg;
    logic [31:0] order_reg;
    logic [1:0]  drag_reg;
    logic [31:0] dwin_reg;
    logic signed [11:0] arow_reg, acol_reg;
    logic signed [11:0] scol_reg, srow_reg;
    logic [10:0] sw_reg, sh_reg;
    logic [1:0]  edges_reg;

    req_t req_reg;
    rsp_t rsp_reg, rsp_next;
    logic [CNT_W-1:0] idx_reg;
    logic found_reg, best_ok_reg;
    logic [SLOT_W-1:0] slot_reg, best_reg;
    logic [31:0] bestz_reg;
    logic [2:0] area_reg;
    logic signed [11:0] nx_reg, ny_reg;
    logic [10:0] nw_reg, nh_reg;
    // Copy of the last entry for remove.
    logic [31:0] c_id_reg, c_z_reg;
    logic signed [11:0] c_col_reg, c_row_reg;
    logic [10:0] c_w_reg, c_h_reg;
    logic [1:0] c_fl_reg;

    logic [SLOT_W-1:0] si;
    logic signed [13:0] fx, fy, fr, fb, mr, mc;
    logic in_frame;
    assign si = idx_reg[SLOT_W-1:0];
    assign mr = 14'(req_reg.mouse_row);
    assign mc = 14'(req_reg.mouse_col);
    assign fx = 14'(e_col[si]) - 14'sd1;
    assign fy = 14'(e_row[si]) - 14'sd1;
    assign fr = 14'(e_col[si]) + 14'($signed({1'b0, e_w[si]})) + 14'sd1;
    assign fb = 14'(e_row[si]) + 14'($signed({1'b0, e_h[si]})) + 14'sd1;
    assign in_frame = mr >= fy && mr < fb && mc >= fx && mc < fr;

    logic [31:0] key;
    assign key = (req_reg.operation == OP_DRAG) ? dwin_reg : req_reg.window_id;

    assign sts.scan_done = (idx_reg >= count_reg);
    assign sts.is_press = req_reg.operation == OP_PRESS;
    assign sts.is_drag = req_reg.operation == OP_DRAG;
    assign sts.is_remove = req_reg.operation == OP_REMOVE && found_reg;

    // Classification of the best hit.
    logic signed [13:0] bx, by, bw, bh, bfx, bfy, bfw, bmx;
    logic [2:0] area_c;
    assign bx = 14'(e_col[best_reg]);
    assign by = 14'(e_row[best_reg]);
    assign bw = 14'($signed({1'b0, e_w[best_reg]}));
    assign bh = 14'($signed({1'b0, e_h[best_reg]}));
    assign bfx = bx - 14'sd1;
    assign bfy = by - 14'sd1;
    assign bfw = bw + 14'sd2;
    assign bmx = bfx + bfw - 14'sd10;

    always_comb
    begin
        area_c = AREA_BORDER;
        if (!best_ok_reg) area_c = AREA_NONE;
        else if (mr == bfy && bfw >= 14'sd12 && mc >= bmx && mc <= bmx + 14'sd2)
            area_c = AREA_MIN;
        else if (mr == bfy && bfw >= 14'sd12 && mc >= bmx + 14'sd3 && mc <= bmx + 14'sd5)
            area_c = AREA_MAX;
        else if (mr == bfy && bfw >= 14'sd12 && mc >= bmx + 14'sd6 && mc <= bmx + 14'sd8)
            area_c = AREA_CLOSE;
        else if (mr == bfy && bfw < 14'sd12 && bfw >= 14'sd6
                 && mc >= bfx + bfw - 14'sd4 && mc <= bfx + bfw - 14'sd2)
            area_c = AREA_CLOSE;
        else if (mr == bfy) area_c = AREA_TITLE;
        else if (e_fl[best_reg][1] && mc == bfx + bfw - 14'sd1 && mr > bfy
                 && mr < bfy + bh + 14'sd1)
            area_c = AREA_SCROLL;
        else if (mr >= by && mr < by + bh && mc >= bx && mc < bx + bw)
            area_c = AREA_CONTENT;
    end

    // Drag arithmetic on the found slot.
    logic signed [13:0] dr, dc, tx, ty, tw, th, mw, mh;
    always_comb
    begin
        dr = mr - 14'(arow_reg);
        dc = mc - 14'(acol_reg);
        mw = 14'($signed({1'b0, min_w_reg}));
        mh = 14'($signed({1'b0, min_h_reg}));
        tx = 14'(e_col[slot_reg]);
        ty = 14'(e_row[slot_reg]);
        tw = 14'($signed({1'b0, e_w[slot_reg]}));
        th = 14'($signed({1'b0, e_h[slot_reg]}));
        if (drag_reg == DRAG_MOVE)
        begin
            tx = 14'(scol_reg) + dc;
            ty = 14'(srow_reg) + dr;
        end
        else if (drag_reg == DRAG_RESIZE)
        begin
            if (edges_reg[0])
            begin
                tw = 14'($signed({1'b0, sw_reg})) - dc;
                tx = 14'(scol_reg) + dc;
            end
            else tw = 14'($signed({1'b0, sw_reg})) + dc;
            if (edges_reg[1])
            begin
                th = 14'($signed({1'b0, sh_reg})) - dr;
                ty = 14'(srow_reg) + dr;
            end
            else th = 14'($signed({1'b0, sh_reg})) + dr;
            if (tw < mw)
            begin
                if (edges_reg[0]) tx = tx - (mw - tw);
                tw = mw;
            end
            if (th < mh)
            begin
                if (edges_reg[1]) ty = ty - (mh - th);
                th = mh;
            end
            if (tw > 14'sd2047) tw = 14'sd2047;
            if (th > 14'sd2047) th = 14'sd2047;
        end
        if (tx > 14'sd2047) tx = 14'sd2047;
        if (tx < -14'sd2048) tx = -14'sd2048;
        if (ty > 14'sd2047) ty = 14'sd2047;
        if (ty < -14'sd2048) ty = -14'sd2048;
    end

    // Result of the request being committed.
    always_comb
    begin
        rsp_next = '0;
        rsp_next.drag_mode = drag_reg;
        case (req_reg.operation)
            OP_ADD:
                if (count_reg >= CNT_W'(MAX_WINDOWS) || found_reg)
                    rsp_next.status = 1'b1;
            OP_REMOVE:
                if (!found_reg) rsp_next.status = 1'b1;
            OP_FLAGS:
                if (!found_reg) rsp_next.status = 1'b1;
            OP_PRESS:
            begin
                rsp_next.hit_area = area_reg;
                if (best_ok_reg)
                begin
                    rsp_next.hit_id = e_id[best_reg];
                    if (area_reg == AREA_TITLE) rsp_next.drag_mode = DRAG_MOVE;
                    else if (area_reg == AREA_BORDER) rsp_next.drag_mode = DRAG_RESIZE;
                    else if (area_reg == AREA_SCROLL) rsp_next.drag_mode = DRAG_SCROLL;
                end
            end
            OP_DRAG:
                if (drag_reg != DRAG_IDLE)
                begin
                    rsp_next.hit_id = dwin_reg;
                    if (!found_reg) rsp_next.drag_mode = DRAG_IDLE;
                    else
                    begin
                        rsp_next.new_col = nx_reg;
                        rsp_next.new_row = ny_reg;
                        rsp_next.new_width = nw_reg;
                        rsp_next.new_height = nh_reg;
                        rsp_next.changed = nx_reg != e_col[slot_reg]
                            || ny_reg != e_row[slot_reg] || nw_reg != e_w[slot_reg]
                            || nh_reg != e_h[slot_reg];
                    end
                end
            OP_RELEASE:
            begin
                rsp_next.drag_mode = DRAG_IDLE;
                if (drag_reg != DRAG_IDLE)
                begin
                    rsp_next.hit_id = dwin_reg;
                    rsp_next.resize_ended = drag_reg == DRAG_RESIZE;
                end
            end
            default: rsp_next.status = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_w_reg <= 8'd10;
            min_h_reg <= 8'd3;
            count_reg <= '0;
            order_reg <= '0;
            drag_reg <= DRAG_IDLE;
            dwin_reg <= '0;
            arow_reg <= '0;
            acol_reg <= '0;
            scol_reg <= '0;
            srow_reg <= '0;
            sw_reg <= '0;
            sh_reg <= '0;
            edges_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == CFG_MIN_WIDTH) min_w_reg <= cfg_data;
                else min_h_reg <= cfg_data;
            end
            if (cmd.execute)
            begin
                case (req_reg.operation)
                    OP_ADD:
                        if (!(count_reg >= CNT_W'(MAX_WINDOWS) || found_reg))
                        begin
                            count_reg <= count_reg + 1'b1;
                            order_reg <= order_reg + 1'b1;
                        end
                    OP_REMOVE: if (found_reg) count_reg <= count_reg - 1'b1;
                    OP_PRESS:
                        if (best_ok_reg)
                        begin
                            order_reg <= order_reg + 1'b1;
                            if (area_reg == AREA_TITLE || area_reg == AREA_BORDER
                                || area_reg == AREA_SCROLL)
                            begin
                                dwin_reg <= e_id[best_reg];
                                arow_reg <= req_reg.mouse_row;
                                acol_reg <= req_reg.mouse_col;
                            end
                            if (area_reg == AREA_TITLE)
                            begin
                                drag_reg <= DRAG_MOVE;
                                scol_reg <= e_col[best_reg];
                                srow_reg <= e_row[best_reg];
                            end
                            else if (area_reg == AREA_BORDER)
                            begin
                                drag_reg <= DRAG_RESIZE;
                                scol_reg <= e_col[best_reg];
                                srow_reg <= e_row[best_reg];
                                sw_reg <= e_w[best_reg];
                                sh_reg <= e_h[best_reg];
                                edges_reg <= {req_reg.mouse_row < e_row[best_reg],
                                              req_reg.mouse_col < e_col[best_reg]};
                            end
                            else if (area_reg == AREA_SCROLL) drag_reg <= DRAG_SCROLL;
                        end
                    OP_DRAG: if (drag_reg != DRAG_IDLE && !found_reg) drag_reg <= DRAG_IDLE;
                    OP_RELEASE: drag_reg <= DRAG_IDLE;
                    default: drag_reg <= drag_reg;
                endcase
            end
        end
    end

    // Table, scan and sequencing registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load) req_reg <= req;
        if (cmd.scan_start)
        begin
            idx_reg <= '0;
            found_reg <= 1'b0;
            best_ok_reg <= 1'b0;
            slot_reg <= '0;
            best_reg <= '0;
            bestz_reg <= '0;
        end
        if (cmd.scan_step && !sts.scan_done)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (!found_reg && e_id[si] == key)
            begin
                found_reg <= 1'b1;
                slot_reg <= si;
            end
            if (!e_fl[si][0] && in_frame && (!best_ok_reg || e_z[si] > bestz_reg))
            begin
                best_ok_reg <= 1'b1;
                best_reg <= si;
                bestz_reg <= e_z[si];
            end
        end
        if (cmd.classify) area_reg <= area_c;
        if (cmd.drag_calc)
        begin
            nx_reg <= tx[11:0];
            ny_reg <= ty[11:0];
            nw_reg <= tw[10:0];
            nh_reg <= th[10:0];
        end
        if (cmd.copy_read)
        begin
            c_id_reg <= e_id[SLOT_W'(count_reg - 1'b1)];
            c_col_reg <= e_col[SLOT_W'(count_reg - 1'b1)];
            c_row_reg <= e_row[SLOT_W'(count_reg - 1'b1)];
            c_w_reg <= e_w[SLOT_W'(count_reg - 1'b1)];
            c_h_reg <= e_h[SLOT_W'(count_reg - 1'b1)];
            c_z_reg <= e_z[SLOT_W'(count_reg - 1'b1)];
            c_fl_reg <= e_fl[SLOT_W'(count_reg - 1'b1)];
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
            case (req_reg.operation)
                OP_ADD:
                    if (!(count_reg >= CNT_W'(MAX_WINDOWS) || found_reg))
                    begin
                        e_id[SLOT_W'(count_reg)] <= req_reg.window_id;
                        e_col[SLOT_W'(count_reg)] <= req_reg.win_col;
                        e_row[SLOT_W'(count_reg)] <= req_reg.win_row;
                        e_w[SLOT_W'(count_reg)] <= req_reg.win_width;
                        e_h[SLOT_W'(count_reg)] <= req_reg.win_height;
                        e_fl[SLOT_W'(count_reg)] <= 2'b00;
                        e_z[SLOT_W'(count_reg)] <= order_reg;
                    end
                OP_REMOVE:
                    if (found_reg)
                    begin
                        e_id[slot_reg] <= c_id_reg;
                        e_col[slot_reg] <= c_col_reg;
                        e_row[slot_reg] <= c_row_reg;
                        e_w[slot_reg] <= c_w_reg;
                        e_h[slot_reg] <= c_h_reg;
                        e_z[slot_reg] <= c_z_reg;
                        e_fl[slot_reg] <= c_fl_reg;
                    end
                OP_FLAGS:
                    if (found_reg) e_fl[slot_reg] <= {req_reg.scrollbar_on, req_reg.minimized};
                OP_PRESS:
                    if (best_ok_reg) e_z[best_reg] <= order_reg;
                OP_DRAG:
                    if (drag_reg != DRAG_IDLE && found_reg)
                    begin
                        e_col[slot_reg] <= nx_reg;
                        e_row[slot_reg] <= ny_reg;
                        e_w[slot_reg] <= nw_reg;
                        e_h[slot_reg] <= nh_reg;
                    end
                default: ;
            endcase
        end
    end

    assign rsp = rsp_reg;

`include "window_hit_test_and_drag_unit_assert.svh"
    `WHT_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CNT_W'(MAX_WINDOWS))
    `WHT_ASSERT_NEXT(a_add_grows, cmd.execute && req_reg.operation == OP_ADD
        && !found_reg && count_reg < CNT_W'(MAX_WINDOWS), count_reg == $past(count_reg) + 1'b1)
    `WHT_ASSERT_IMP(a_scan_bound, cmd.scan_step, idx_reg <= count_reg)
endmodule

>>> rtl/core/window_hit_test_and_drag_unit.sv
// ----------------------------------------------------------------------------
// window_hit_test_and_drag_unit
// Window table with hit testing and move/resize drags.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/ready): add, remove, set flags, press, drag
// and release. Each request gives exactly one result on rsp.
// A request passes through accept, a table scan that visits one entry per
// cycle, one more step for a press (classify), a drag (geometry) or a
// successful remove (copy of the last entry), and a commit; the result is
// then held until its transfer.
// One request is in flight at a time; req.ready is low from accept until the
// result transfer completes, so a stalled receiver simply holds the result.
// Reset empties the table, ends any drag and restores the minimum sizes
// 10 and 3. Configuration writes (cfg_we, cfg_index, cfg_data) set the
// minimum width (index 0) and height (index 1); the user is bound to make
// them only while the unit is idle, which the unit itself does not enforce.
module window_hit_test_and_drag_unit (
    input  logic        clk,
    input  logic        rst_n,
    wht_req_if.sink     req,
    wht_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import wht_pkg::*;

    cmd_t cmd;
    sts_t sts;

    wht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .cmd(cmd), .sts(sts)
    );

    wht_dp u_dp (
        .clk(clk), .rst_n(rst_n),
        .req(req.data), .rsp(rsp.data),
        .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_idx(cfg_index[0]), .cfg_data(cfg_data)
    );
endmodule

>>> verif/wht_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wht_tb_if
// Extra interface used by the testbench beside the RTL channels.
// The RTL channel interfaces are reused as they are; this file carries the
// configuration-write bundle the checker watches.
// ----------------------------------------------------------------------------
interface wht_cfg_if;
    logic       we;
    logic [0:0] index;
    logic [7:0] data;
    modport source (output we, output index, output data);
    modport sink (input we, input index, input data);
endinterface

>>> verif/wht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wht_checker
// Watches the request, result and configuration ports of the window unit,
// keeps its own copy of the window table and drag state, predicts each
// result and compares it field by field.
// ----------------------------------------------------------------------------
module wht_checker
    import wht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    wht_req_if.sink  req,
    wht_rsp_if.sink  rsp,
    wht_cfg_if.sink  cfg,
    output int       fail_count,
    output int       pending,
    output int       n_results,
    output int       n_hits
);
    typedef struct {
        logic [31:0] id;
        int          col;
        int          row;
        int          wd;
        int          ht;
        logic [31:0] order;
        logic [1:0]  flags;
    } window_t;

    window_t     table_q[$];
    logic [31:0] next_order;
    logic [1:0]  drag_state;
    logic [31:0] drag_id;
    int          grab_row, grab_col;
    int          start_col, start_row, start_wd, start_ht;
    logic [1:0]  edges;
    int          min_wd, min_ht;
    rsp_t        expected_q[$];

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int find_window(logic [31:0] id);
        foreach (table_q[i])
            if (table_q[i].id == id)
                return i;
        return -1;
    endfunction

    function automatic int locate_hit(int r, int c, output logic [2:0] area);
        int best;
        logic [31:0] best_z;
        int fx, fy, fw, fh, mx;
        best = -1;
        best_z = 0;
        area = AREA_NONE;
        foreach (table_q[i])
        begin
            if (table_q[i].flags[0])
                continue;
            fx = table_q[i].col - 1;
            fy = table_q[i].row - 1;
            fw = table_q[i].wd + 2;
            fh = table_q[i].ht + 2;
            if (r >= fy && r < fy + fh && c >= fx && c < fx + fw
                && (best < 0 || table_q[i].order > best_z))
            begin
                best = i;
                best_z = table_q[i].order;
            end
        end
        if (best < 0)
            return -1;
        fx = table_q[best].col - 1;
        fy = table_q[best].row - 1;
        fw = table_q[best].wd + 2;
        fh = table_q[best].ht + 2;
        if (r == fy && fw >= 12)
        begin
            mx = fx + fw - 10;
            if (c >= mx && c <= mx + 2)
                area = AREA_MIN;
            else if (c >= mx + 3 && c <= mx + 5)
                area = AREA_MAX;
            else if (c >= mx + 6 && c <= mx + 8)
                area = AREA_CLOSE;
        end
        else if (r == fy && fw >= 6 && c >= fx + fw - 4 && c <= fx + fw - 2)
            area = AREA_CLOSE;
        if (area != AREA_NONE)
            return best;
        if (r == fy)
            area = AREA_TITLE;
        else if (table_q[best].flags[1] && c == fx + fw - 1 && r > fy && r < fy + fh - 1)
            area = AREA_SCROLL;
        else if (r >= fy + 1 && r < fy + 1 + table_q[best].ht
                 && c >= fx + 1 && c < fx + 1 + table_q[best].wd)
            area = AREA_CONTENT;
        else
            area = AREA_BORDER;
        return best;
    endfunction

    function automatic rsp_t predict_window_op(req_t it);
        rsp_t res;
        int s, mr, mc, dr, dc, nx, ny, nw, nh;
        logic [2:0] area;
        window_t w;
        res = '0;
        mr = int'(it.mouse_row);
        mc = int'(it.mouse_col);
        case (it.operation)
            OP_ADD:
                if (table_q.size() >= MAX_WINDOWS || find_window(it.window_id) >= 0)
                    res.status = 1'b1;
                else
                begin
                    w.id = it.window_id;
                    w.col = int'(it.win_col);
                    w.row = int'(it.win_row);
                    w.wd = int'(it.win_width);
                    w.ht = int'(it.win_height);
                    w.flags = 2'b00;
                    w.order = next_order;
                    next_order++;
                    table_q.push_back(w);
                end
            OP_REMOVE:
            begin
                s = find_window(it.window_id);
                if (s < 0)
                    res.status = 1'b1;
                else
                begin
                    table_q[s] = table_q[table_q.size() - 1];
                    void'(table_q.pop_back());
                end
            end
            OP_FLAGS:
            begin
                s = find_window(it.window_id);
                if (s < 0)
                    res.status = 1'b1;
                else
                    table_q[s].flags = {it.scrollbar_on, it.minimized};
            end
            OP_PRESS:
            begin
                s = locate_hit(mr, mc, area);
                res.hit_area = area;
                if (s >= 0)
                begin
                    n_hits++;
                    res.hit_id = table_q[s].id;
                    table_q[s].order = next_order;
                    next_order++;
                    if (area inside {AREA_TITLE, AREA_BORDER, AREA_SCROLL})
                    begin
                        drag_id = table_q[s].id;
                        grab_row = mr;
                        grab_col = mc;
                    end
                    if (area == AREA_TITLE)
                    begin
                        drag_state = DRAG_MOVE;
                        start_col = table_q[s].col;
                        start_row = table_q[s].row;
                    end
                    else if (area == AREA_BORDER)
                    begin
                        drag_state = DRAG_RESIZE;
                        start_col = table_q[s].col;
                        start_row = table_q[s].row;
                        start_wd = table_q[s].wd;
                        start_ht = table_q[s].ht;
                        edges = {mr < table_q[s].row, mc < table_q[s].col};
                    end
                    else if (area == AREA_SCROLL)
                        drag_state = DRAG_SCROLL;
                end
            end
            OP_DRAG:
                if (drag_state != DRAG_IDLE)
                begin
                    res.hit_id = drag_id;
                    s = find_window(drag_id);
                    if (s < 0)
                        drag_state = DRAG_IDLE;
                    else
                    begin
                        dr = mr - grab_row;
                        dc = mc - grab_col;
                        nx = table_q[s].col;
                        ny = table_q[s].row;
                        nw = table_q[s].wd;
                        nh = table_q[s].ht;
                        if (drag_state == DRAG_MOVE)
                        begin
                            nx = clampi(start_col + dc, -2048, 2047);
                            ny = clampi(start_row + dr, -2048, 2047);
                        end
                        else if (drag_state == DRAG_RESIZE)
                        begin
                            if (edges[0])
                            begin
                                nw = start_wd - dc;
                                nx = start_col + dc;
                            end
                            else
                                nw = start_wd + dc;
                            if (edges[1])
                            begin
                                nh = start_ht - dr;
                                ny = start_row + dr;
                            end
                            else
                                nh = start_ht + dr;
                            if (nw < min_wd)
                            begin
                                if (edges[0])
                                    nx -= min_wd - nw;
                                nw = min_wd;
                            end
                            if (nh < min_ht)
                            begin
                                if (edges[1])
                                    ny -= min_ht - nh;
                                nh = min_ht;
                            end
                            nw = clampi(nw, 0, 2047);
                            nh = clampi(nh, 0, 2047);
                            nx = clampi(nx, -2048, 2047);
                            ny = clampi(ny, -2048, 2047);
                        end
                        if (nx != table_q[s].col || ny != table_q[s].row
                            || nw != table_q[s].wd || nh != table_q[s].ht)
                        begin
                            res.changed = 1'b1;
                            table_q[s].col = nx;
                            table_q[s].row = ny;
                            table_q[s].wd = nw;
                            table_q[s].ht = nh;
                        end
                        res.new_col = 12'(nx);
                        res.new_row = 12'(ny);
                        res.new_width = 11'(nw);
                        res.new_height = 11'(nh);
                    end
                end
            OP_RELEASE:
                if (drag_state != DRAG_IDLE)
                begin
                    res.hit_id = drag_id;
                    res.resize_ended = drag_state == DRAG_RESIZE;
                    drag_state = DRAG_IDLE;
                end
            default:
                res.status = 1'b1;
        endcase
        res.drag_mode = drag_state;
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        if (!rst_n)
        begin
            table_q.delete();
            expected_q.delete();
            next_order = '0;
            drag_state = DRAG_IDLE;
            drag_id = '0;
            grab_row = 0;
            grab_col = 0;
            start_col = 0;
            start_row = 0;
            start_wd = 0;
            start_ht = 0;
            edges = '0;
            min_wd = 10;
            min_ht = 3;
            fail_count = 0;
            pending = 0;
            n_results = 0;
            n_hits = 0;
        end
        else
        begin
            if (cfg.we)
            begin
                if (cfg.index == CFG_MIN_WIDTH)
                    min_wd = int'(cfg.data);
                else
                    min_ht = int'(cfg.data);
            end
            if (req.valid && req.ready)
                expected_q.push_back(predict_window_op(req.data));
            if (rsp.valid && rsp.ready)
            begin
                got = rsp.data;
                n_results++;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected", $time);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.status !== want.status)
                        report("status", 32'(got.status), 32'(want.status));
                    if (got.hit_area !== want.hit_area)
                        report("hit_area", 32'(got.hit_area), 32'(want.hit_area));
                    if (got.hit_id !== want.hit_id)
                        report("hit_id", got.hit_id, want.hit_id);
                    if (got.drag_mode !== want.drag_mode)
                        report("drag_mode", 32'(got.drag_mode), 32'(want.drag_mode));
                    if (got.changed !== want.changed)
                        report("changed", 32'(got.changed), 32'(want.changed));
                    if (got.new_col !== want.new_col)
                        report("new_col", 32'(got.new_col), 32'(want.new_col));
                    if (got.new_row !== want.new_row)
                        report("new_row", 32'(got.new_row), 32'(want.new_row));
                    if (got.new_width !== want.new_width)
                        report("new_width", 32'(got.new_width), 32'(want.new_width));
                    if (got.new_height !== want.new_height)
                        report("new_height", 32'(got.new_height), 32'(want.new_height));
                    if (got.resize_ended !== want.resize_ended)
                        report("resize_ended", 32'(got.resize_ended),
                               32'(want.resize_ended));
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

>>> verif/tb_window_hit_test_and_drag_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_hit_test_and_drag_unit
// Drives window-table requests and minimum-size writes into the unit.
// A directed opening covers table limits, all hit areas but the border
// and the move and scroll drags; random phases then build small window
// stacks and run press, drag and release sequences, random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_window_hit_test_and_drag_unit;
    import wht_pkg::*;

    logic clk;
    logic rst_n;
    logic rsp_ready;
    logic quiet;
    int   stall_left;
    int   fail_count, pending, n_results, n_hits, n_items;
    logic [31:0] ids[$];

    wht_req_if req ();
    wht_rsp_if rsp ();
    wht_cfg_if cfg ();

    window_hit_test_and_drag_unit dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .cfg_we(cfg.we), .cfg_index(cfg.index), .cfg_data(cfg.data)
    );

    wht_checker checker_i (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.sink), .cfg(cfg.sink),
        .fail_count(fail_count), .pending(pending), .n_results(n_results),
        .n_hits(n_hits)
    );

    assign rsp.ready = rsp_ready;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // The receiver stalls in random bursts until the quiet tail of the run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b1;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            rsp_ready <= stall_left == 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left <= int'($urandom_range(0, 6));
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    task automatic send(req_t it);
        if (!quiet && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 7))
                @(posedge clk);
        req.data <= it;
        req.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req.ready);
        req.valid <= 1'b0;
        // Step past the accept edge so that valid is dropped and raised again
        // in different time steps; the unit is busy here anyway.
        @(posedge clk);
        n_items++;
    endtask

    function automatic req_t blank_op(logic [2:0] op);
        req_t it;
        it = '0;
        it.operation = op;
        return it;
    endfunction

    task automatic add_window(logic [31:0] id, int c, int r, int w, int h);
        req_t it;
        it = blank_op(OP_ADD);
        it.window_id = id;
        it.win_col = 12'(c);
        it.win_row = 12'(r);
        it.win_width = 11'(w);
        it.win_height = 11'(h);
        send(it);
    endtask

    task automatic pointer_op(logic [2:0] op, int r, int c);
        req_t it;
        it = blank_op(op);
        it.mouse_row = 12'(r);
        it.mouse_col = 12'(c);
        send(it);
    endtask

    task automatic set_flags(logic [31:0] id, logic mn, logic sb);
        req_t it;
        it = blank_op(OP_FLAGS);
        it.window_id = id;
        it.minimized = mn;
        it.scrollbar_on = sb;
        send(it);
    endtask

    task automatic drain_then_config(logic [0:0] idx, logic [7:0] value);
        while (pending != 0)
            @(posedge clk);
        repeat (25)
            @(posedge clk);
        cfg.we <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        cfg.we <= 1'b0;
    endtask

    // A random request, mostly aimed at existing windows and near their frames.
    task automatic random_op();
        req_t it;
        int pick;
        it = '0;
        {it.window_id, it.win_col, it.win_row} = 56'({$urandom, $urandom});
        it.win_width = $urandom_range(0, 9) == 0 ? 11'($urandom) : 11'($urandom_range(0, 30));
        it.win_height = $urandom_range(0, 9) == 0 ? 11'($urandom) : 11'($urandom_range(0, 12));
        it.minimized = $urandom_range(0, 3) == 0;
        it.scrollbar_on = 1'($urandom);
        pick = int'($urandom_range(0, 99));
        if ($urandom_range(0, 3) != 0)
        begin
            it.mouse_row = $signed(12'($urandom_range(0, 24))) - 12'sd2;
            it.mouse_col = $signed(12'($urandom_range(0, 40))) - 12'sd2;
        end
        else
            {it.mouse_row, it.mouse_col} = 24'($urandom);
        if (pick < 14)
        begin
            it.operation = OP_ADD;
            if ($urandom_range(0, 3) != 0)
            begin
                it.win_col = 12'($urandom_range(0, 30));
                it.win_row = 12'($urandom_range(0, 20));
                it.window_id = $urandom_range(1, 40);
            end
            ids.push_back(it.window_id);
        end
        else if (pick < 22)
            it.operation = OP_REMOVE;
        else if (pick < 30)
            it.operation = OP_FLAGS;
        else if (pick < 55)
            it.operation = OP_PRESS;
        else if (pick < 85)
            it.operation = OP_DRAG;
        else if (pick < 97)
            it.operation = OP_RELEASE;
        else
            it.operation = 3'($urandom_range(6, 7));
        if (it.operation inside {OP_REMOVE, OP_FLAGS} && ids.size() > 0
            && $urandom_range(0, 4) != 0)
            it.window_id = ids[$urandom_range(0, ids.size() - 1)];
        if (it.operation == OP_FLAGS && $urandom_range(0, 1) == 0)
            it.minimized = 1'b0;
        send(it);
    endtask

    initial
    begin
        req_t it;
        int wait_cycles;
        quiet = 1'b0;
        n_items = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.data = '0;
        cfg.we = 1'b0;
        cfg.index = CFG_MIN_WIDTH;
        cfg.data = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: limits, every hit area but the border, move and scroll drags.
        pointer_op(OP_DRAG, 0, 0);
        pointer_op(OP_RELEASE, 0, 0);
        pointer_op(OP_PRESS, 0, 0);
        add_window(32'hFFFF_FFFF, 10, 10, 20, 6);
        add_window(32'hFFFF_FFFF, 0, 0, 1, 1);
        add_window(32'd0, -2048, -2048, 2047, 2047);
        add_window(32'd7, 2047, 2047, 0, 0);
        add_window(32'd8, 40, 2, 6, 3);
        pointer_op(OP_PRESS, 1, 44);
        pointer_op(OP_PRESS, 9, 21);
        pointer_op(OP_PRESS, 9, 24);
        pointer_op(OP_PRESS, 9, 27);
        set_flags(32'hFFFF_FFFF, 1'b0, 1'b1);
        pointer_op(OP_PRESS, 12, 30);
        pointer_op(OP_DRAG, 20, 30);
        pointer_op(OP_PRESS, 12, 15);
        pointer_op(OP_PRESS, 9, 9);
        pointer_op(OP_DRAG, 2040, 2040);
        pointer_op(OP_RELEASE, 0, 0);
        pointer_op(OP_PRESS, 9, 12);
        pointer_op(OP_DRAG, -2048, -2048);
        pointer_op(OP_RELEASE, 0, 0);
        set_flags(32'd99, 1'b1, 1'b1);
        send(blank_op(3'd6));
        send(blank_op(3'd7));
        it = blank_op(OP_REMOVE);
        it.window_id = 32'd0;
        send(it);
        drain_then_config(CFG_MIN_WIDTH, 8'd1);
        drain_then_config(CFG_MIN_HEIGHT, 8'd255);

        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase == 4)
                quiet = 1'b1;
            // Fill the table past full, then run mixed traffic.
            repeat (17)
                add_window($urandom_range(1, 40), $urandom_range(0, 30),
                           $urandom_range(0, 20), $urandom_range(0, 30),
                           $urandom_range(0, 12));
            repeat (107)
                random_op();
            drain_then_config(phase[0] ? CFG_MIN_WIDTH : CFG_MIN_HEIGHT,
                              phase == 1 ? 8'd255 : 8'($urandom_range(1, 255)));
        end

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (30)
            @(posedge clk);
        $display("Sent %0d requests, checked %0d results, %0d presses hit a window.",
                 n_items, n_results, n_hits);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
